// File: hdl/arpc_pkg.sv
package arpc_pkg;

    localparam int ARPC_TABLE_ENTRIES = 16;
    localparam int CFG_DATA_W         = 48;

    localparam logic [15:0] HTYPE_ETH  = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ARP_OP_REQ = 16'h0001;

    localparam logic [31:0] BCAST_IP  = 32'hFFFF_FFFF;
    localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] CMD_RX_ARP  = 2'd0;
    localparam logic [1:0] CMD_RESOLVE = 2'd1;
    localparam logic [1:0] CMD_DELETE  = 2'd2;

    localparam logic CFG_OWN_MAC = 1'b0;
    localparam logic CFG_OWN_IP  = 1'b1;

    typedef enum logic [1:0] {
        FOP_NONE    = 2'd0,
        FOP_REQUEST = 2'd1,
        FOP_REPLY   = 2'd2
    } frame_op_t;

    typedef enum logic [3:0] {
        ST_BAD_TYPE  = 4'd0,
        ST_LEARNED   = 4'd1,
        ST_REFRESHED = 4'd2,
        ST_FULL      = 4'd3,
        ST_HIT       = 4'd4,
        ST_BCAST     = 4'd5,
        ST_MISS      = 4'd6,
        ST_DELETED   = 4'd7,
        ST_NOT_FOUND = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        K_LEARN   = 2'd0,
        K_RESOLVE = 2'd1,
        K_DELETE  = 2'd2
    } kind_t;

    // Token that walks the row of cells; phase 1 of a learn claims a free entry
    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic        phase;
        logic [31:0] ip;
        logic [47:0] mac;
        logic        found;
        logic [47:0] hit_mac;
    } tok_t;

    typedef struct packed {
        status_t     status;
        logic [47:0] resolved_mac;
        logic        send_frame;
        frame_op_t   frame_op;
        logic [47:0] frame_dest_mac;
        logic [47:0] frame_target_mac;
        logic [31:0] frame_target_ip;
    } res_t;

endpackage

// File: hdl/arpc_in_if.sv
interface arpc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [15:0] arp_op;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] query_ip;

    modport source (
        output valid, cmd, hw_type, proto_type, arp_op, sender_mac, sender_ip, query_ip,
        input  ready
    );
    modport sink (
        input  valid, cmd, hw_type, proto_type, arp_op, sender_mac, sender_ip, query_ip,
        output ready
    );
endinterface

// File: hdl/arpc_out_if.sv
interface arpc_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [47:0] resolved_mac;
    logic        send_frame;
    logic [1:0]  frame_op;
    logic [47:0] frame_dest_mac;
    logic [47:0] frame_target_mac;
    logic [31:0] frame_target_ip;

    modport source (
        output valid, status, resolved_mac, send_frame, frame_op, frame_dest_mac,
               frame_target_mac, frame_target_ip,
        input  ready
    );
    modport sink (
        input  valid, status, resolved_mac, send_frame, frame_op, frame_dest_mac,
               frame_target_mac, frame_target_ip,
        output ready
    );
endinterface

// File: hdl/arpc_cell.sv
module arpc_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  arpc_pkg::tok_t tok_in,
    output arpc_pkg::tok_t tok_out
);
    import arpc_pkg::*;

    logic        valid_reg, valid_next;
    logic [31:0] ip_reg, ip_next;
    logic [47:0] mac_reg, mac_next;
    tok_t        tok_reg, tok_next;
    logic        match;

    assign match   = valid_reg && (ip_reg == tok_in.ip);
    assign tok_out = tok_reg;

    always_comb
    begin
        valid_next = valid_reg;
        ip_next    = ip_reg;
        mac_next   = mac_reg;
        tok_next   = tok_in;
        if (tok_in.valid)
        begin
            unique case (tok_in.kind)
                K_LEARN:
                begin
                    if (!tok_in.phase)
                    begin
                        if (match && !tok_in.found)
                        begin
                            mac_next       = tok_in.mac;
                            tok_next.found = 1'b1;
                        end
                    end
                    else if (!valid_reg && !tok_in.found)
                    begin
                        valid_next     = 1'b1;
                        ip_next        = tok_in.ip;
                        mac_next       = tok_in.mac;
                        tok_next.found = 1'b1;
                    end
                end
                K_RESOLVE:
                begin
                    if (match && !tok_in.found)
                    begin
                        tok_next.found   = 1'b1;
                        tok_next.hit_mac = mac_reg;
                    end
                end
                K_DELETE:
                begin
                    if (match)
                    begin
                        valid_next     = 1'b0;
                        tok_next.found = 1'b1;
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ip_reg  <= ip_next;
        mac_reg <= mac_next;
    end

endmodule

// File: hdl/arp_cache_responder.sv
// ARP cache and responder. One item is handled at a time; the table is a row of
// TABLE_ENTRIES cells and a lookup token moves one cell per cycle. A resolve or
// delete, and a received packet whose sender is already stored, gives its result
// after one walk of the row; a received packet whose sender is new needs a second
// walk to claim the lowest free entry. Bad-type packets, unused commands and
// broadcast resolves skip the walk.
// The finished result sits in an output register, so the next item can be taken
// while it waits. own_mac and own_ip are held for the sender fields of the frame
// builder downstream and are not shown on the result.
module arp_cache_responder #(
    parameter int TABLE_ENTRIES = arpc_pkg::ARPC_TABLE_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    arpc_in_if.sink                         arp_in,
    arpc_out_if.source                      arp_out,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import arpc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    tok_t        inj_reg, inj_next;
    res_t        res_reg, res_next;
    res_t        out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    logic        is_req_reg, is_req_next;
    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;
    tok_t        tok [TABLE_ENTRIES+1];
    tok_t        tail;

    assign tok[0] = inj_reg;
    assign tail   = tok[TABLE_ENTRIES];

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++)
        begin : g_cell
            arpc_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (tok[g]),
                .tok_out (tok[g+1])
            );
        end
    endgenerate

    assign arp_in.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        inj_next       = '0;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        is_req_next    = is_req_reg;

        if (out_valid_reg && arp_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (arp_in.valid)
                begin
                    is_req_next = (arp_in.arp_op == ARP_OP_REQ);
                    res_next    = '0;
                    state_next  = S_RUN;
                    priority if (arp_in.cmd == CMD_RX_ARP)
                    begin
                        if (arp_in.hw_type == HTYPE_ETH && arp_in.proto_type == PTYPE_IPV4)
                        begin
                            inj_next.valid = 1'b1;
                            inj_next.kind  = K_LEARN;
                            inj_next.ip    = arp_in.sender_ip;
                            inj_next.mac   = arp_in.sender_mac;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else if (arp_in.cmd == CMD_RESOLVE)
                    begin
                        if (arp_in.query_ip == BCAST_IP)
                        begin
                            res_next.status       = ST_BCAST;
                            res_next.resolved_mac = BCAST_MAC;
                            state_next            = S_DONE;
                        end
                        else
                        begin
                            inj_next.valid = 1'b1;
                            inj_next.kind  = K_RESOLVE;
                            inj_next.ip    = arp_in.query_ip;
                        end
                    end
                    else if (arp_in.cmd == CMD_DELETE)
                    begin
                        inj_next.valid = 1'b1;
                        inj_next.kind  = K_DELETE;
                        inj_next.ip    = arp_in.query_ip;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_RUN:
            begin
                if (tail.valid)
                begin
                    state_next = S_DONE;
                    res_next   = '0;
                    unique case (tail.kind)
                        K_LEARN:
                        begin
                            if (!tail.phase && !tail.found)
                            begin
                                inj_next       = tail;
                                inj_next.phase = 1'b1;
                                state_next     = S_RUN;
                            end
                            else
                            begin
                                if (!tail.phase)
                                    res_next.status = ST_REFRESHED;
                                else if (tail.found)
                                    res_next.status = ST_LEARNED;
                                else
                                    res_next.status = ST_FULL;
                                if (is_req_reg)
                                begin
                                    res_next.send_frame       = 1'b1;
                                    res_next.frame_op         = FOP_REPLY;
                                    res_next.frame_dest_mac   = tail.mac;
                                    res_next.frame_target_mac = tail.mac;
                                    res_next.frame_target_ip  = tail.ip;
                                end
                            end
                        end
                        K_RESOLVE:
                        begin
                            if (tail.found && tail.hit_mac != BCAST_MAC)
                            begin
                                res_next.status       = ST_HIT;
                                res_next.resolved_mac = tail.hit_mac;
                            end
                            else
                            begin
                                res_next.status           = ST_MISS;
                                res_next.resolved_mac     = BCAST_MAC;
                                res_next.send_frame       = 1'b1;
                                res_next.frame_op         = FOP_REQUEST;
                                res_next.frame_dest_mac   = BCAST_MAC;
                                res_next.frame_target_mac = BCAST_MAC;
                                res_next.frame_target_ip  = tail.ip;
                            end
                        end
                        K_DELETE:
                        begin
                            res_next.status = tail.found ? ST_DELETED : ST_NOT_FOUND;
                        end
                        default:
                        begin
                            res_next.status = ST_BAD_TYPE;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || arp_out.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            inj_reg       <= '0;
            out_valid_reg <= 1'b0;
            own_mac_reg   <= '0;
            own_ip_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            inj_reg       <= inj_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == CFG_OWN_MAC)
                own_mac_reg <= cfg_data[47:0];
            if (cfg_we && cfg_index == CFG_OWN_IP)
                own_ip_reg <= cfg_data[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        out_reg    <= out_next;
        is_req_reg <= is_req_next;
    end

    assign arp_out.valid            = out_valid_reg;
    assign arp_out.status           = out_reg.status;
    assign arp_out.resolved_mac     = out_reg.resolved_mac;
    assign arp_out.send_frame       = out_reg.send_frame;
    assign arp_out.frame_op         = out_reg.frame_op;
    assign arp_out.frame_dest_mac   = out_reg.frame_dest_mac;
    assign arp_out.frame_target_mac = out_reg.frame_target_mac;
    assign arp_out.frame_target_ip  = out_reg.frame_target_ip;

endmodule

// File: dv/tb_arp_cache_responder.sv
`timescale 1ns / 100ps

module tb_arp_cache_responder;
    import arpc_pkg::*;

    localparam logic [1:0]  CMD_UNUSED    = 2'd3;
    localparam logic [15:0] ARP_OP_REPLY  = 16'h0002;
    localparam logic [31:0] IP_HOST       = 32'hC0A8_0A01;
    localparam int          POOL_SIZE     = 20;
    localparam int          PHASE_ITEMS   = 460;
    localparam int          LEARN_LATENCY = 2 * ARPC_TABLE_ENTRIES + 3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [15:0] arp_op;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] query_ip;
    } arp_item_t;

    typedef struct packed {
        arp_item_t item;
        logic      typed;
        res_t      want;
    } directed_row_t;

    localparam res_t RES_BAD_TYPE = '{ST_BAD_TYPE, 48'd0, 1'b0, FOP_NONE, 48'd0, 48'd0, 32'd0};
    localparam res_t RES_BCAST    = '{ST_BCAST, BCAST_MAC, 1'b0, FOP_NONE, 48'd0, 48'd0, 32'd0};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    arpc_in_if  arp_in ();
    arpc_out_if arp_out ();

    arp_cache_responder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .arp_in    (arp_in),
        .arp_out   (arp_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mirror of the cache and registers
    logic        cache_valid [ARPC_TABLE_ENTRIES];
    logic [31:0] cache_ip    [ARPC_TABLE_ENTRIES];
    logic [47:0] cache_mac   [ARPC_TABLE_ENTRIES];
    logic [47:0] own_mac_copy;
    logic [31:0] own_ip_copy;

    res_t          pending_answers [$];
    logic [31:0]   ip_pool [POOL_SIZE];
    directed_row_t directed_rows [14];
    int            status_tally [9];
    int            mismatches;
    int            items_sent;
    int            settings_used;
    logic          calm;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_arp_cache_responder failed");
        $finish;
    end

    function automatic int cache_slot_of(logic [31:0] ip);
        for (int i = 0; i < ARPC_TABLE_ENTRIES; i++)
        begin
            if (cache_valid[i] && cache_ip[i] == ip)
                return i;
        end
        return -1;
    endfunction

    function automatic res_t arp_cache_answer(arp_item_t it);
        res_t r;
        int   slot;
        r = RES_BAD_TYPE;
        slot = -1;
        case (it.cmd)
            CMD_RX_ARP:
            begin
                if (it.hw_type == HTYPE_ETH && it.proto_type == PTYPE_IPV4)
                begin
                    slot = cache_slot_of(it.sender_ip);
                    if (slot >= 0)
                    begin
                        cache_mac[slot] = it.sender_mac;
                        r.status = ST_REFRESHED;
                    end
                    else
                    begin
                        for (int i = ARPC_TABLE_ENTRIES - 1; i >= 0; i--)
                        begin
                            if (!cache_valid[i])
                                slot = i;
                        end
                        if (slot >= 0)
                        begin
                            cache_valid[slot] = 1'b1;
                            cache_ip[slot]    = it.sender_ip;
                            cache_mac[slot]   = it.sender_mac;
                            r.status = ST_LEARNED;
                        end
                        else
                            r.status = ST_FULL;
                    end
                    if (it.arp_op == ARP_OP_REQ)
                    begin
                        r.send_frame       = 1'b1;
                        r.frame_op         = FOP_REPLY;
                        r.frame_dest_mac   = it.sender_mac;
                        r.frame_target_mac = it.sender_mac;
                        r.frame_target_ip  = it.sender_ip;
                    end
                end
            end
            CMD_RESOLVE:
            begin
                if (it.query_ip == BCAST_IP)
                    r = RES_BCAST;
                else
                begin
                    slot = cache_slot_of(it.query_ip);
                    if (slot >= 0 && cache_mac[slot] != BCAST_MAC)
                    begin
                        r.status       = ST_HIT;
                        r.resolved_mac = cache_mac[slot];
                    end
                    else
                    begin
                        r.status           = ST_MISS;
                        r.resolved_mac     = BCAST_MAC;
                        r.send_frame       = 1'b1;
                        r.frame_op         = FOP_REQUEST;
                        r.frame_dest_mac   = BCAST_MAC;
                        r.frame_target_mac = BCAST_MAC;
                        r.frame_target_ip  = it.query_ip;
                    end
                end
            end
            CMD_DELETE:
            begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < ARPC_TABLE_ENTRIES; i++)
                begin
                    if (cache_valid[i] && cache_ip[i] == it.query_ip)
                    begin
                        cache_valid[i] = 1'b0;
                        r.status = ST_DELETED;
                    end
                end
            end
            default:
                r = RES_BAD_TYPE;
        endcase
        return r;
    endfunction

    // mostly addresses that are stored or in the pool, so hits and deletes happen
    function automatic logic [31:0] pick_query_ip();
        int r;
        int slot;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            slot = $urandom_range(0, ARPC_TABLE_ENTRIES - 1);
            for (int i = 0; i < ARPC_TABLE_ENTRIES; i++)
            begin
                if (cache_valid[(slot + i) % ARPC_TABLE_ENTRIES])
                    return cache_ip[(slot + i) % ARPC_TABLE_ENTRIES];
            end
        end
        if (r < 85)
            return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic arp_item_t random_item();
        arp_item_t it;
        int        pick;
        it.cmd        = CMD_RX_ARP;
        it.hw_type    = HTYPE_ETH;
        it.proto_type = PTYPE_IPV4;
        it.arp_op     = ARP_OP_REQ;
        it.sender_mac = 48'({$urandom, $urandom});
        it.sender_ip  = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
        it.query_ip   = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: it.arp_op = ARP_OP_REQ;
                5, 6, 7:       it.arp_op = ARP_OP_REPLY;
                default:       it.arp_op = 16'($urandom);
            endcase
            if ($urandom_range(0, 9) == 0)
                it.sender_ip = $urandom;
            if ($urandom_range(0, 9) == 0)
                it.sender_mac = BCAST_MAC;
        end
        else if (pick < 70)
        begin
            it.cmd = CMD_RESOLVE;
            it.query_ip = ($urandom_range(0, 19) == 0) ? BCAST_IP : pick_query_ip();
        end
        else if (pick < 88)
        begin
            it.cmd = CMD_DELETE;
            it.query_ip = pick_query_ip();
        end
        else if (pick < 96)
        begin
            it.arp_op    = 16'($urandom);
            it.sender_ip = $urandom;
            case ($urandom_range(0, 2))
                0:       it.hw_type = 16'($urandom);
                1:       it.proto_type = 16'($urandom);
                default:
                begin
                    it.hw_type    = 16'($urandom);
                    it.proto_type = 16'($urandom);
                end
            endcase
        end
        else
        begin
            it.cmd        = CMD_UNUSED;
            it.hw_type    = 16'($urandom);
            it.proto_type = 16'($urandom);
            it.arp_op     = 16'($urandom);
            it.sender_ip  = $urandom;
        end
        return it;
    endfunction

    task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_OWN_MAC)
            own_mac_copy = value;
        else
            own_ip_copy = value[31:0];
    endtask

    task automatic send_item(arp_item_t it, logic typed, res_t want);
        res_t answer;
        @(negedge clk);
        arp_in.valid      <= 1'b1;
        arp_in.cmd        <= it.cmd;
        arp_in.hw_type    <= it.hw_type;
        arp_in.proto_type <= it.proto_type;
        arp_in.arp_op     <= it.arp_op;
        arp_in.sender_mac <= it.sender_mac;
        arp_in.sender_ip  <= it.sender_ip;
        arp_in.query_ip   <= it.query_ip;
        @(posedge clk);
        while (arp_in.ready !== 1'b1)
            @(posedge clk);
        answer = arp_cache_answer(it);
        if (typed)
            answer = want;
        pending_answers = {pending_answers, answer};
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        arp_in.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(string field, logic [47:0] want, logic [47:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %h got %h", $time, field, want, got);
        end
    endtask

    initial
    begin : sink_side
        int   stall_left;
        int   mode_left;
        logic stalls_on;
        stall_left = 0;
        mode_left  = 60;
        stalls_on  = 1'b1;
        arp_out.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                stalls_on = !stalls_on;
                mode_left = $urandom_range(20, 200);
            end
            else
                mode_left--;
            if (calm || !stalls_on)
                arp_out.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                arp_out.ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                arp_out.ready <= 1'b0;
                stall_left = $urandom_range(0, 10);
            end
            else
                arp_out.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : watch_results
        res_t want;
        if (rst_n === 1'b1 && arp_out.valid === 1'b1 && arp_out.ready === 1'b1)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no item pending: expected none, got status %0d",
                         $time, arp_out.status);
            end
            else
            begin
                want = pending_answers.pop_front();
                check_field("status", 48'(want.status), 48'(arp_out.status));
                check_field("resolved_mac", want.resolved_mac, arp_out.resolved_mac);
                check_field("send_frame", 48'(want.send_frame), 48'(arp_out.send_frame));
                check_field("frame_op", 48'(want.frame_op), 48'(arp_out.frame_op));
                check_field("frame_dest_mac", want.frame_dest_mac, arp_out.frame_dest_mac);
                check_field("frame_target_mac", want.frame_target_mac,
                            arp_out.frame_target_mac);
                check_field("frame_target_ip", 48'(want.frame_target_ip),
                            48'(arp_out.frame_target_ip));
                if (arp_out.status < 4'd9)
                    status_tally[arp_out.status]++;
            end
        end
    end

    initial
    begin : stimulus
        arp_item_t it;
        int        gap_left;
        logic      gappy;

        calm          = 1'b0;
        mismatches    = 0;
        items_sent    = 0;
        settings_used = 0;
        own_mac_copy  = '0;
        own_ip_copy   = '0;
        foreach (status_tally[s])
            status_tally[s] = 0;
        foreach (cache_valid[i])
        begin
            cache_valid[i] = 1'b0;
            cache_ip[i]    = '0;
            cache_mac[i]   = '0;
        end
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_OWN_MAC;
        cfg_data          <= '0;
        arp_in.valid      <= 1'b0;
        arp_in.cmd        <= CMD_RX_ARP;
        arp_in.hw_type    <= '0;
        arp_in.proto_type <= '0;
        arp_in.arp_op     <= '0;
        arp_in.sender_mac <= '0;
        arp_in.sender_ip  <= '0;
        arp_in.query_ip   <= '0;

        directed_rows = '{
            '{'{CMD_RESOLVE, 16'h0, 16'h0, 16'h0, 48'h0, 32'h0, IP_HOST}, 1'b1,
              '{ST_MISS, BCAST_MAC, 1'b1, FOP_REQUEST, BCAST_MAC, BCAST_MAC, IP_HOST}},
            '{'{CMD_RESOLVE, 16'h0, 16'h0, 16'h0, 48'h0, 32'h0, BCAST_IP}, 1'b1, RES_BCAST},
            '{'{CMD_RX_ARP, 16'hFFFF, PTYPE_IPV4, ARP_OP_REQ, 48'h0123_4567_89AB, IP_HOST,
                32'h0}, 1'b1, RES_BAD_TYPE},
            '{'{CMD_RX_ARP, HTYPE_ETH, 16'h0000, ARP_OP_REQ, 48'h0123_4567_89AB, IP_HOST,
                32'h0}, 1'b1, RES_BAD_TYPE},
            '{'{CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, BCAST_MAC, BCAST_IP, BCAST_IP},
              1'b1, RES_BAD_TYPE},
            '{'{CMD_RX_ARP, HTYPE_ETH, PTYPE_IPV4, ARP_OP_REQ, 48'h0, 32'h0, 32'h0}, 1'b1,
              '{ST_LEARNED, 48'h0, 1'b1, FOP_REPLY, 48'h0, 48'h0, 32'h0}},
            '{'{CMD_RX_ARP, HTYPE_ETH, PTYPE_IPV4, ARP_OP_REPLY, BCAST_MAC, BCAST_IP, 32'h0},
              1'b1, '{ST_LEARNED, 48'h0, 1'b0, FOP_NONE, 48'h0, 48'h0, 32'h0}},
            '{'{CMD_RX_ARP, HTYPE_ETH, PTYPE_IPV4, ARP_OP_REQ, BCAST_MAC, 32'h0, 32'h0},
              1'b0, '0},
            '{'{CMD_RESOLVE, 16'h0, 16'h0, 16'h0, 48'h0, 32'h0, 32'h0}, 1'b0, '0},
            '{'{CMD_RX_ARP, HTYPE_ETH, PTYPE_IPV4, 16'hFFFF, 48'hA5A5_5A5A_C3C3, IP_HOST,
                32'h0}, 1'b0, '0},
            '{'{CMD_RESOLVE, 16'h0, 16'h0, 16'h0, 48'h0, 32'h0, IP_HOST}, 1'b0, '0},
            '{'{CMD_DELETE, 16'h0, 16'h0, 16'h0, 48'h0, 32'h0, 32'h0}, 1'b0, '0},
            '{'{CMD_DELETE, 16'h0, 16'h0, 16'h0, 48'h0, 32'h0, 32'h0}, 1'b0, '0},
            '{'{CMD_RESOLVE, 16'h0, 16'h0, 16'h0, 48'h0, 32'h0, BCAST_IP}, 1'b1, RES_BCAST}
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_OWN_MAC, BCAST_MAC);
        write_reg(CFG_OWN_IP, 48'd0);
        settings_used++;

        foreach (directed_rows[r])
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);

        // two entries are held now: fill the rest, then one sender more than fits
        for (int n = 0; n < ARPC_TABLE_ENTRIES - 1; n++)
        begin
            it = '{CMD_RX_ARP, HTYPE_ETH, PTYPE_IPV4, ARP_OP_REQ, 48'({$urandom, $urandom}),
                   32'h0A00_0100 + n, 32'h0};
            send_item(it, 1'b0, '0);
        end
        drain_results();

        gappy    = 1'b1;
        gap_left = 40;
        for (int phase = 1; phase <= 4; phase++)
        begin
            case (phase)
                1:
                begin
                    write_reg(CFG_OWN_MAC, 48'd0);
                    write_reg(CFG_OWN_IP, 48'(BCAST_IP));
                end
                3:
                begin
                    write_reg(CFG_OWN_MAC, BCAST_MAC);
                    write_reg(CFG_OWN_IP, 48'd0);
                end
                default:
                begin
                    write_reg(CFG_OWN_MAC, 48'({$urandom, $urandom}));
                    write_reg(CFG_OWN_IP, 48'($urandom));
                end
            endcase
            settings_used++;
            foreach (ip_pool[k])
                ip_pool[k] = $urandom;
            if (phase % 2 == 0)
            begin
                ip_pool[0] = 32'h0;
                ip_pool[1] = BCAST_IP;
            end
            calm = (phase == 4);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    drain_results();
                send_item(random_item(), 1'b0, '0);
                if (gap_left == 0)
                begin
                    gappy    = !gappy;
                    gap_left = $urandom_range(20, 120);
                end
                else
                    gap_left--;
                if (!calm && gappy && $urandom_range(0, 4) == 0)
                begin
                    repeat ($urandom_range(1, 11))
                    begin
                        @(negedge clk);
                        arp_in.valid <= 1'b0;
                    end
                end
            end
            drain_results();
        end

        repeat (LEARN_LATENCY + 8) @(posedge clk);

        $display("run covered %0d items under %0d register settings, %0d mismatching fields",
                 items_sent, settings_used, mismatches);
        $display("learned %0d refreshed %0d full %0d hit %0d broadcast %0d miss %0d",
                 status_tally[ST_LEARNED], status_tally[ST_REFRESHED], status_tally[ST_FULL],
                 status_tally[ST_HIT], status_tally[ST_BCAST], status_tally[ST_MISS]);
        $display("deleted %0d not found %0d bad type %0d",
                 status_tally[ST_DELETED], status_tally[ST_NOT_FOUND],
                 status_tally[ST_BAD_TYPE]);
        if (mismatches == 0)
            $display("tb_arp_cache_responder passed");
        else
            $display("tb_arp_cache_responder failed");
        $finish;
    end

endmodule
